/* sv/ihs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared constants, codes and memory word layouts of the heap scheduler.
// ----------------------------------------------------------------------------
package ihs_pkg;

  // heap entries and hash slots (slot count must be a power of two)
  localparam int HEAP_DEPTH  = 64;
  localparam int TABLE_SLOTS = 128;
  localparam int PW          = $clog2(HEAP_DEPTH);
  localparam int SW          = $clog2(TABLE_SLOTS);
  localparam int CW          = 7;
  localparam int LIM_MAX     = (HEAP_DEPTH < TABLE_SLOTS - 1) ? HEAP_DEPTH : TABLE_SLOTS - 1;

  // action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DONE   = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;
  localparam logic [1:0] ACT_RETIME = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_NOTFD = 2'd3;

  // slot kinds
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_TOMB  = 2'd1;
  localparam logic [1:0] SLOT_USED  = 2'd2;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [31:0] tm;
    logic               done;
    logic [SW-1:0]      slot;
  } heap_entry_t;

  typedef struct packed {
    logic [1:0]    kind;
    logic [15:0]   id;
    logic [PW-1:0] pos;
  } slot_entry_t;

  localparam int HEW = $bits(heap_entry_t);
  localparam int SEW = $bits(slot_entry_t);

  typedef struct packed {
    logic            we;
    logic [PW-1:0]   waddr;
    heap_entry_t     wdata;
    logic            re;
    logic [PW-1:0]   raddr;
  } heap_req_t;

  typedef struct packed {
    logic            we;
    logic [SW-1:0]   waddr;
    slot_entry_t     wdata;
    logic            re;
    logic [SW-1:0]   raddr;
  } slot_req_t;

endpackage
`default_nettype wire

/* sv/ihs_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_in_if
// Request channel: action, task id and time value with valid/ready.
// ----------------------------------------------------------------------------
interface ihs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        task_id;
  logic signed [31:0] time_value;

  modport source (output valid, action, task_id, time_value, input ready);
  modport sink   (input valid, action, task_id, time_value, output ready);
endinterface
`default_nettype wire

/* sv/ihs_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_out_if
// Result channel: status, heap root and task count with valid/ready.
// ----------------------------------------------------------------------------
interface ihs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               head_valid;
  logic [15:0]        head_id;
  logic signed [31:0] head_time;
  logic               head_done;
  logic [6:0]         task_count;

  modport source (output valid, status, head_valid, head_id, head_time, head_done,
                  task_count, input ready);
  modport sink   (input valid, status, head_valid, head_id, head_time, head_done,
                  task_count, output ready);
endinterface
`default_nettype wire

/* sv/indexed_min_heap_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_scheduler
// Task scheduler: binary min-heap on time with a hashed id-to-position table.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. The id lookup probes the hash table
// one slot at a time (read, then check); an add then sifts up, each level a
// parent read and a write, and cancel and time change sift up or else down,
// each down level reading the children and moving the smaller one up. Every
// action ends by reading the root and loading the result register; an add
// turned away as full skips the lookup, and a long probe chain lengthens the
// lookup. The result register lets the next request be accepted while the
// previous result waits.
module indexed_min_heap_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ihs_in_if.sink           in_i,
  ihs_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [ihs_pkg::CW-1:0] cap;
  ihs_pkg::heap_req_t     heap_req;
  ihs_pkg::slot_req_t     slot_req;
  ihs_pkg::heap_entry_t   heap_rd;
  ihs_pkg::slot_entry_t   slot_rd;

  // configuration registers
  ihs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cap_o (cap)
  );

  // heap entries
  ihs_ram #(.WIDTH(ihs_pkg::HEW), .DEPTH(ihs_pkg::HEAP_DEPTH)) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_req.we),
    .waddr_i (heap_req.waddr),
    .wdata_i (heap_req.wdata),
    .re_i    (heap_req.re),
    .raddr_i (heap_req.raddr),
    .rdata_o (heap_rd)
  );

  // hash slots
  ihs_ram #(.WIDTH(ihs_pkg::SEW), .DEPTH(ihs_pkg::TABLE_SLOTS)) u_slot (
    .clk_i   (clk_i),
    .we_i    (slot_req.we),
    .waddr_i (slot_req.waddr),
    .wdata_i (slot_req.wdata),
    .re_i    (slot_req.re),
    .raddr_i (slot_req.raddr),
    .rdata_o (slot_rd)
  );

  // sequencer
  ihs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_i, .out_o,
    .cap_i     (cap),
    .heap_o    (heap_req),
    .heap_rd_i (heap_rd),
    .slot_o    (slot_req),
    .slot_rd_i (slot_rd)
  );

endmodule
`default_nettype wire

/* sv/ihs_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/ihs_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_cfg
// APB register port holding the capacity register.
// ----------------------------------------------------------------------------
module ihs_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output logic [ihs_pkg::CW-1:0] cap_o
);

  logic [ihs_pkg::CW-1:0] cap_q, cap_d;
  logic                   hit;

  assign hit    = (paddr[2] == 1'b0);
  assign pready = 1'b1;

  // register write
  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && hit) begin
      cap_d = pwdata[ihs_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ihs_pkg::CW'(64);
    end else begin
      cap_q <= cap_d;
    end
  end

  // read back
  assign prdata = hit ? {{(32 - ihs_pkg::CW){1'b0}}, cap_q} : 32'd0;
  assign cap_o  = cap_q;

endmodule
`default_nettype wire

/* sv/ihs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ihs_ctrl
// Sequencer: hash probe, heap read-modify-write and sift steps.
// ----------------------------------------------------------------------------
module ihs_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  ihs_in_if.sink                      in_i,
  ihs_out_if.source                   out_o,
  input  wire logic [ihs_pkg::CW-1:0] cap_i,
  output ihs_pkg::heap_req_t          heap_o,
  input  wire ihs_pkg::heap_entry_t   heap_rd_i,
  output ihs_pkg::slot_req_t          slot_o,
  input  wire ihs_pkg::slot_entry_t   slot_rd_i
);

  localparam int PW = ihs_pkg::PW;
  localparam int SW = ihs_pkg::SW;
  localparam int CW = ihs_pkg::CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRB   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_DISP  = 4'd3;
  localparam logic [3:0] S_RMW   = 4'd4;
  localparam logic [3:0] S_CAN   = 4'd5;
  localparam logic [3:0] S_SU_RD = 4'd6;
  localparam logic [3:0] S_SU_CM = 4'd7;
  localparam logic [3:0] S_SD_RL = 4'd8;
  localparam logic [3:0] S_SD_RR = 4'd9;
  localparam logic [3:0] S_SD_CM = 4'd10;
  localparam logic [3:0] S_PLACE = 4'd11;
  localparam logic [3:0] S_ROOT  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0]           st_q, st_d;
  logic [1:0]           act_q, act_d;
  logic [15:0]          id_q, id_d;
  logic signed [31:0]   tv_q, tv_d;
  logic [SW-1:0]        h_q, h_d, n_q, n_d, free_q, free_d, fslot_q, fslot_d;
  logic                 fvld_q, fvld_d, found_q, found_d;
  logic [PW-1:0]        fpos_q, fpos_d, i_q, i_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 moved_q, moved_d, down_q, down_d, rvld_q, rvld_d;
  ihs_pkg::heap_entry_t cur_q, cur_d, lch_q, lch_d;
  logic [1:0]           stat_q, stat_d;
  logic [ihs_pkg::TABLE_SLOTS-1:0] svld_q, svld_d;
  logic                 vrd_q, vrd_d;

  // result register
  logic                 ov_q, ov_d;
  logic [1:0]           ost_q, ost_d;
  logic                 ohv_q, ohv_d, ohd_q, ohd_d;
  logic [15:0]          ohid_q, ohid_d;
  logic signed [31:0]   oht_q, oht_d;
  logic [CW-1:0]        ocnt_q, ocnt_d;

  // helpers
  logic [CW-1:0]        lim, last;
  logic [1:0]           kind;
  logic [PW-1:0]        par;
  logic [PW+1:0]        lidx, ridx;
  logic                 take_l, take_r;
  logic signed [31:0]   mtime;

  assign lim  = (cap_i > CW'(ihs_pkg::LIM_MAX)) ? CW'(ihs_pkg::LIM_MAX) : cap_i;
  assign last = cnt_q - CW'(1);
  assign kind = vrd_q ? slot_rd_i.kind : ihs_pkg::SLOT_EMPTY;
  assign par  = (i_q - PW'(1)) >> 1;
  assign lidx = ({2'b00, i_q} << 1) + (PW+2)'(1);
  assign ridx = ({2'b00, i_q} << 1) + (PW+2)'(2);
  assign take_l = ($signed(lch_q.tm) < $signed(cur_q.tm));
  assign mtime  = take_l ? lch_q.tm : cur_q.tm;
  assign take_r = rvld_q && ($signed(heap_rd_i.tm) < mtime);

  assign in_i.ready       = (st_q == S_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.status     = ost_q;
  assign out_o.head_valid = ohv_q;
  assign out_o.head_id    = ohid_q;
  assign out_o.head_time  = oht_q;
  assign out_o.head_done  = ohd_q;
  assign out_o.task_count = ocnt_q;

  // sequencer
  always_comb begin
    st_d = st_q; act_d = act_q; id_d = id_q; tv_d = tv_q;
    h_d = h_q; n_d = n_q; free_d = free_q; fvld_d = fvld_q;
    found_d = found_q; fslot_d = fslot_q; fpos_d = fpos_q;
    cnt_d = cnt_q; i_d = i_q; moved_d = moved_q; down_d = down_q; rvld_d = rvld_q;
    cur_d = cur_q; lch_d = lch_q; stat_d = stat_q; svld_d = svld_q; vrd_d = vrd_q;
    ov_d = ov_q; ost_d = ost_q; ohv_d = ohv_q; ohd_d = ohd_q;
    ohid_d = ohid_q; oht_d = oht_q; ocnt_d = ocnt_q;
    heap_o = '0;
    slot_o = '0;

    if (ov_q && out_o.ready) begin
      ov_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d  = in_i.action;
          id_d   = in_i.task_id;
          tv_d   = in_i.time_value;
          stat_d = ihs_pkg::ST_OK;
          h_d    = in_i.task_id[SW-1:0];
          n_d    = '0;
          fvld_d = 1'b0;
          if (in_i.action == ihs_pkg::ACT_ADD && cnt_q >= lim) begin
            stat_d = ihs_pkg::ST_FULL;
            st_d   = S_ROOT;
          end else begin
            st_d = S_PRB;
          end
        end
      end
      // probe read
      S_PRB: begin
        slot_o.re    = 1'b1;
        slot_o.raddr = h_q;
        vrd_d        = svld_q[h_q];
        st_d         = S_CHK;
      end
      // probe check
      S_CHK: begin
        if (kind == ihs_pkg::SLOT_USED && slot_rd_i.id == id_q) begin
          found_d = 1'b1;
          fslot_d = h_q;
          fpos_d  = slot_rd_i.pos;
          st_d    = S_DISP;
        end else if (kind == ihs_pkg::SLOT_EMPTY) begin
          if (!fvld_q) begin
            free_d = h_q;
            fvld_d = 1'b1;
          end
          found_d = 1'b0;
          st_d    = S_DISP;
        end else begin
          if (kind == ihs_pkg::SLOT_TOMB && !fvld_q) begin
            free_d = h_q;
            fvld_d = 1'b1;
          end
          if (n_q == SW'(ihs_pkg::TABLE_SLOTS - 1)) begin
            found_d = 1'b0;
            st_d    = S_DISP;
          end else begin
            n_d  = n_q + SW'(1);
            h_d  = h_q + SW'(1);
            st_d = S_PRB;
          end
        end
      end
      // act on the lookup
      S_DISP: begin
        if (act_q == ihs_pkg::ACT_ADD) begin
          if (found_q) begin
            stat_d = ihs_pkg::ST_DUP;
            st_d   = S_ROOT;
          end else begin
            cur_d.id   = id_q;
            cur_d.tm   = tv_q;
            cur_d.done = 1'b0;
            cur_d.slot = free_q;
            i_d        = cnt_q[PW-1:0];
            cnt_d      = cnt_q + CW'(1);
            moved_d    = 1'b0;
            down_d     = 1'b0;
            st_d       = S_SU_RD;
          end
        end else if (!found_q) begin
          stat_d = ihs_pkg::ST_NOTFD;
          st_d   = S_ROOT;
        end else if (act_q == ihs_pkg::ACT_CANCEL) begin
          slot_o.we         = 1'b1;
          slot_o.waddr      = fslot_q;
          slot_o.wdata.kind = ihs_pkg::SLOT_TOMB;
          slot_o.wdata.id   = id_q;
          slot_o.wdata.pos  = fpos_q;
          svld_d[fslot_q]   = 1'b1;
          if (fpos_q == last[PW-1:0]) begin
            cnt_d = last;
            st_d  = S_ROOT;
          end else begin
            heap_o.re    = 1'b1;
            heap_o.raddr = last[PW-1:0];
            st_d         = S_CAN;
          end
        end else begin
          heap_o.re    = 1'b1;
          heap_o.raddr = fpos_q;
          st_d         = S_RMW;
        end
      end
      // completed mark or new time
      S_RMW: begin
        if (act_q == ihs_pkg::ACT_DONE) begin
          heap_o.we         = 1'b1;
          heap_o.waddr      = fpos_q;
          heap_o.wdata      = heap_rd_i;
          heap_o.wdata.done = 1'b1;
          st_d              = S_ROOT;
        end else begin
          cur_d    = heap_rd_i;
          cur_d.tm = tv_q;
          i_d      = fpos_q;
          moved_d  = 1'b0;
          down_d   = 1'b1;
          st_d     = S_SU_RD;
        end
      end
      // last entry fills the hole
      S_CAN: begin
        cur_d   = heap_rd_i;
        i_d     = fpos_q;
        cnt_d   = last;
        moved_d = 1'b0;
        down_d  = 1'b1;
        st_d    = S_SU_RD;
      end
      // sift up: fetch parent
      S_SU_RD: begin
        if (i_q == '0) begin
          st_d = (down_q && !moved_q) ? S_SD_RL : S_PLACE;
        end else begin
          heap_o.re    = 1'b1;
          heap_o.raddr = par;
          st_d         = S_SU_CM;
        end
      end
      // sift up: parent stays or moves down into the hole
      S_SU_CM: begin
        if ($signed(heap_rd_i.tm) <= $signed(cur_q.tm)) begin
          st_d = (down_q && !moved_q) ? S_SD_RL : S_PLACE;
        end else begin
          heap_o.we         = 1'b1;
          heap_o.waddr      = i_q;
          heap_o.wdata      = heap_rd_i;
          slot_o.we         = 1'b1;
          slot_o.waddr      = heap_rd_i.slot;
          slot_o.wdata.kind = ihs_pkg::SLOT_USED;
          slot_o.wdata.id   = heap_rd_i.id;
          slot_o.wdata.pos  = i_q;
          svld_d[heap_rd_i.slot] = 1'b1;
          i_d     = par;
          moved_d = 1'b1;
          st_d    = S_SU_RD;
        end
      end
      // sift down: fetch left child
      S_SD_RL: begin
        if (lidx < {1'b0, cnt_q}) begin
          heap_o.re    = 1'b1;
          heap_o.raddr = lidx[PW-1:0];
          st_d         = S_SD_RR;
        end else begin
          st_d = S_PLACE;
        end
      end
      // sift down: fetch right child
      S_SD_RR: begin
        lch_d = heap_rd_i;
        if (ridx < {1'b0, cnt_q}) begin
          heap_o.re    = 1'b1;
          heap_o.raddr = ridx[PW-1:0];
          rvld_d       = 1'b1;
        end else begin
          rvld_d = 1'b0;
        end
        st_d = S_SD_CM;
      end
      // sift down: smaller child moves up into the hole
      S_SD_CM: begin
        if (take_r || take_l) begin
          heap_o.we         = 1'b1;
          heap_o.waddr      = i_q;
          heap_o.wdata      = take_r ? heap_rd_i : lch_q;
          slot_o.we         = 1'b1;
          slot_o.waddr      = heap_o.wdata.slot;
          slot_o.wdata.kind = ihs_pkg::SLOT_USED;
          slot_o.wdata.id   = heap_o.wdata.id;
          slot_o.wdata.pos  = i_q;
          svld_d[heap_o.wdata.slot] = 1'b1;
          i_d  = take_r ? ridx[PW-1:0] : lidx[PW-1:0];
          st_d = S_SD_RL;
        end else begin
          st_d = S_PLACE;
        end
      end
      // moving task lands
      S_PLACE: begin
        heap_o.we         = 1'b1;
        heap_o.waddr      = i_q;
        heap_o.wdata      = cur_q;
        slot_o.we         = 1'b1;
        slot_o.waddr      = cur_q.slot;
        slot_o.wdata.kind = ihs_pkg::SLOT_USED;
        slot_o.wdata.id   = cur_q.id;
        slot_o.wdata.pos  = i_q;
        svld_d[cur_q.slot] = 1'b1;
        st_d              = S_ROOT;
      end
      S_ROOT: begin
        heap_o.re    = 1'b1;
        heap_o.raddr = '0;
        st_d         = S_FIN;
      end
      // hand the result to the output register
      S_FIN: begin
        if (!ov_q || out_o.ready) begin
          ov_d   = 1'b1;
          ost_d  = stat_q;
          ocnt_d = cnt_q;
          ohv_d  = (cnt_q != '0);
          ohid_d = (cnt_q != '0) ? heap_rd_i.id : 16'd0;
          oht_d  = (cnt_q != '0) ? heap_rd_i.tm : 32'sd0;
          ohd_d  = (cnt_q != '0) ? heap_rd_i.done : 1'b0;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      svld_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      svld_q <= svld_d;
      ov_q   <= ov_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d; id_q <= id_d; tv_q <= tv_d;
    h_q <= h_d; n_q <= n_d; free_q <= free_d; fvld_q <= fvld_d;
    found_q <= found_d; fslot_q <= fslot_d; fpos_q <= fpos_d;
    i_q <= i_d; moved_q <= moved_d; down_q <= down_d; rvld_q <= rvld_d;
    cur_q <= cur_d; lch_q <= lch_d; stat_q <= stat_d; vrd_q <= vrd_d;
    ost_q <= ost_d; ohv_q <= ohv_d; ohd_q <= ohd_d;
    ohid_q <= ohid_d; oht_q <= oht_d; ocnt_q <= ocnt_d;
  end

endmodule
`default_nettype wire
